@@ sv/rai_pkg.sv @@
package rai_pkg;

   localparam int FIELD_W = 4;
   localparam int IMM_W   = 32;
   localparam int PRINT_W = 32;

   typedef enum logic [FIELD_W-1:0] {
      OP_ADD     = 4'd0,
      OP_MUL     = 4'd1,
      OP_SUB     = 4'd2,
      OP_DIV     = 4'd3,
      OP_COPY    = 4'd4,
      OP_IMM     = 4'd5,
      OP_LESS    = 4'd6,
      OP_GREATER = 4'd7,
      OP_EQUAL   = 4'd8,
      OP_PRINT   = 4'd9,
      OP_NOT     = 4'd10,
      OP_OR      = 4'd11,
      OP_AND     = 4'd12,
      OP_NOP     = 4'd13
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WAIT
   } state_type;

   typedef struct packed {
      logic start;
      logic is_div;
   } md_cmd_type;

   // wraps a register field into the file; four conditional subtracts
   // cover every value of a four-bit field
   function automatic logic [FIELD_W-1:0] reg_reduce(logic [FIELD_W-1:0] f,
                                                     int unsigned n);
      int unsigned t;
      t = 32'(f);
      for (int k = FIELD_W - 1; k >= 0; k--) begin
         if (t >= (n << k)) begin
            t = t - (n << k);
         end
      end
      return FIELD_W'(t);
   endfunction

endpackage

@@ sv/rai_regfile.sv @@
module rai_regfile import rai_pkg::*; #(
   parameter int NUM_REGS   = 16,
   parameter int DATA_WIDTH = 32,
   parameter int IDX_W      = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  logic [IDX_W-1:0]      rd_a_addr,
   input  logic [IDX_W-1:0]      rd_b_addr,
   output logic [DATA_WIDTH-1:0] rd_a_data,
   output logic [DATA_WIDTH-1:0] rd_b_data,
   input  logic                  wr_en,
   input  logic [IDX_W-1:0]      wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data
);

   logic [DATA_WIDTH-1:0] mem [NUM_REGS];
   logic [NUM_REGS-1:0]   vld_ff;
   logic [NUM_REGS-1:0]   vld_in;
   logic [DATA_WIDTH-1:0] rd_a_ff;
   logic [DATA_WIDTH-1:0] rd_b_ff;

   // an entry never written reads as zero
   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= vld_ff[rd_a_addr] ? mem[rd_a_addr] : '0;
         rd_b_ff <= vld_ff[rd_b_addr] ? mem[rd_b_addr] : '0;
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

@@ sv/rai_muldiv.sv @@
module rai_muldiv import rai_pkg::*; #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  md_cmd_type            cmd,
   input  logic [DATA_WIDTH-1:0] op_a,
   input  logic [DATA_WIDTH-1:0] op_b,
   output logic                  done,
   output logic [DATA_WIDTH-1:0] result
);

   localparam int DW = DATA_WIDTH;
   localparam int CW = $clog2(DW);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          is_div_ff, is_div_in;
   logic          neg_ff, neg_in;
   logic          zero_ff, zero_in;
   logic [DW-1:0] acc_ff, acc_in;
   logic [DW-1:0] q_ff, q_in;
   logic [DW-1:0] dvs_ff, dvs_in;
   logic [DW:0]   rem_sh;
   logic [DW:0]   rem_diff;
   logic [DW-1:0] mag_a;
   logic [DW-1:0] mag_b;

   assign mag_a    = op_a[DW-1] ? DW'(0) - op_a : op_a;
   assign mag_b    = op_b[DW-1] ? DW'(0) - op_b : op_b;
   assign rem_sh   = {acc_ff, q_ff[DW-1]};
   assign rem_diff = rem_sh - {1'b0, dvs_ff};

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      is_div_in = is_div_ff;
      neg_in    = neg_ff;
      zero_in   = zero_ff;
      acc_in    = acc_ff;
      q_in      = q_ff;
      dvs_in    = dvs_ff;
      if (cmd.start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         is_div_in = cmd.is_div;
         acc_in    = '0;
         if (cmd.is_div) begin
            q_in    = mag_a;
            dvs_in  = mag_b;
            neg_in  = op_a[DW-1] ^ op_b[DW-1];
            zero_in = (op_b == '0);
         end else begin
            q_in    = op_b;
            dvs_in  = op_a;
            neg_in  = 1'b0;
            zero_in = 1'b0;
         end
      end else if (busy_ff) begin
         if (is_div_ff) begin
            // restoring step: one quotient bit per cycle
            if (!rem_diff[DW]) begin
               acc_in = rem_diff[DW-1:0];
               q_in   = {q_ff[DW-2:0], 1'b1};
            end else begin
               acc_in = rem_sh[DW-1:0];
               q_in   = {q_ff[DW-2:0], 1'b0};
            end
         end else begin
            // shift-add from the multiplier msb, low half only
            acc_in = {acc_ff[DW-2:0], 1'b0} + (q_ff[DW-1] ? dvs_ff : '0);
            q_in   = {q_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      is_div_ff <= is_div_in;
      neg_ff    <= neg_in;
      zero_ff   <= zero_in;
      acc_ff    <= acc_in;
      q_ff      <= q_in;
      dvs_ff    <= dvs_in;
   end

   always_comb begin
      if (!is_div_ff) begin
         result = acc_ff;
      end else if (zero_ff) begin
         result = '0;
      end else if (neg_ff) begin
         result = DW'(0) - q_ff;
      end else begin
         result = q_ff;
      end
   end

   assign done = done_ff;

endmodule

@@ sv/register_alu_interpreter.sv @@
// Runs one decoded three-address instruction per transfer against a file of
// NUM_REGS registers of DATA_WIDTH bits, all zero after reset. Source operands
// come out of the register file in the cycle after acceptance, so add, sub,
// copy, immediate, compare, logic, print and nop go from idle to execute and
// back to idle. Multiply and divide share one bit-serial unit that does one bit
// per cycle and stay in the wait state until it is done. A print also waits while
// the previous printed result has not yet been taken. Register fields wrap
// modulo NUM_REGS; opcodes 14 and 15 act as nop.
module register_alu_interpreter import rai_pkg::*; #(
   parameter int NUM_REGS   = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [FIELD_W-1:0]        req_type,
   input  logic [FIELD_W-1:0]        req_dest_reg,
   input  logic [FIELD_W-1:0]        req_src_b_reg,
   input  logic [FIELD_W-1:0]        req_src_c_reg,
   input  logic signed [IMM_W-1:0]   req_immediate,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [FIELD_W-1:0]        rsp_printed_reg,
   output logic signed [PRINT_W-1:0] rsp_printed_value
);

   localparam int DW    = DATA_WIDTH;
   localparam int IDX_W = $clog2(NUM_REGS);

   state_type             state_ff, state_in;
   opcode_type            op_ff;
   logic [IDX_W-1:0]      dst_ff;
   logic [FIELD_W-1:0]    dreg_ff;
   logic [DW-1:0]         imm_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0]    rsp_reg_ff;
   logic [PRINT_W-1:0]    rsp_value_ff;

   logic                  accept;
   logic                  rsp_load;
   logic [IDX_W-1:0]      rd_a_addr;
   logic [IDX_W-1:0]      rd_b_addr;
   logic [DW-1:0]         opnd_b;
   logic [DW-1:0]         opnd_c;
   logic                  wr_en;
   logic [DW-1:0]         wr_data;
   logic [DW-1:0]         alu_res;
   logic                  alu_wr;
   md_cmd_type            md_cmd;
   logic                  md_done;
   logic [DW-1:0]         md_result;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // a print reads its destination through port a
   assign rd_a_addr = (req_type == OP_PRINT) ? IDX_W'(reg_reduce(req_dest_reg, NUM_REGS))
                                             : IDX_W'(reg_reduce(req_src_b_reg, NUM_REGS));
   assign rd_b_addr = IDX_W'(reg_reduce(req_src_c_reg, NUM_REGS));

   rai_regfile #(
      .NUM_REGS   (NUM_REGS),
      .DATA_WIDTH (DW),
      .IDX_W      (IDX_W)
   ) u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (opnd_b),
      .rd_b_data (opnd_c),
      .wr_en     (wr_en),
      .wr_addr   (dst_ff),
      .wr_data   (wr_data)
   );

   rai_muldiv #(
      .DATA_WIDTH (DW)
   ) u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .cmd    (md_cmd),
      .op_a   (opnd_b),
      .op_b   (opnd_c),
      .done   (md_done),
      .result (md_result)
   );

   always_comb begin
      alu_res = '0;
      alu_wr  = 1'b1;
      case (op_ff)
         OP_ADD:     alu_res = opnd_b + opnd_c;
         OP_SUB:     alu_res = opnd_b - opnd_c;
         OP_COPY:    alu_res = opnd_b;
         OP_IMM:     alu_res = imm_ff;
         OP_LESS:    alu_res = DW'($signed(opnd_b) < $signed(opnd_c));
         OP_GREATER: alu_res = DW'($signed(opnd_c) < $signed(opnd_b));
         OP_EQUAL:   alu_res = DW'(opnd_b == opnd_c);
         OP_NOT:     alu_res = DW'(opnd_b == '0);
         OP_OR:      alu_res = DW'((opnd_b != '0) || (opnd_c != '0));
         OP_AND:     alu_res = DW'((opnd_b != '0) && (opnd_c != '0));
         default:    alu_wr  = 1'b0;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      md_cmd.start  = 1'b0;
      md_cmd.is_div = (op_ff == OP_DIV);
      wr_en         = 1'b0;
      wr_data       = alu_res;
      rsp_load      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (op_ff == OP_MUL || op_ff == OP_DIV) begin
               md_cmd.start = 1'b1;
               state_in     = ST_WAIT;
            end else if (op_ff == OP_PRINT) begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_load = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               wr_en    = alu_wr;
               state_in = ST_IDLE;
            end
         end
         ST_WAIT: begin
            wr_data = md_result;
            if (md_done) begin
               wr_en    = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= opcode_type'(req_type);
         dst_ff  <= IDX_W'(reg_reduce(req_dest_reg, NUM_REGS));
         dreg_ff <= req_dest_reg;
         imm_ff  <= DW'(req_immediate);
      end
      if (rsp_load) begin
         rsp_reg_ff   <= dreg_ff;
         rsp_value_ff <= PRINT_W'(signed'(opnd_b));
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_printed_reg   = rsp_reg_ff;
   assign rsp_printed_value = signed'(rsp_value_ff);

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      md_done |-> state_ff == ST_WAIT)
      else $error("serial unit finished outside the wait state");

   a_write_not_idle: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> state_ff != ST_IDLE)
      else $error("register write while idle");

   a_print_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && op_ff == OP_PRINT && rsp_valid_ff && !rsp_ready)
      |=> state_ff == ST_EXEC)
      else $error("print left execute with the result register full");

   a_print_loads: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("print result not presented");

endmodule

@@ tb/register_alu_interpreter_test.sv @@
`timescale 1ns / 100ps

module register_alu_interpreter_test;
   import rai_pkg::*;

   localparam logic [FIELD_W-1:0] OP_RSVD_14 = 4'd14;
   localparam logic [FIELD_W-1:0] OP_RSVD_15 = 4'd15;
   localparam logic signed [31:0] MIN_VALUE = 32'sh8000_0000;
   localparam logic signed [31:0] MAX_VALUE = 32'sh7fff_ffff;
   localparam int RANDOM_ITEMS = 1525;
   localparam int HOLD_AT      = 500;
   localparam int HOLD_CYCLES  = 400;
   localparam int CALM_FROM    = 900;
   localparam int CALM_TO      = 1200;
   localparam int DRAIN_CYCLES = 60;
   localparam int CYCLE_LIMIT  = 400000;

   typedef struct packed {
      logic [FIELD_W-1:0]        reg_index;
      logic signed [PRINT_W-1:0] value;
   } printed_line_type;

   typedef struct packed {
      logic [FIELD_W-1:0]      op;
      logic [FIELD_W-1:0]      dest;
      logic [FIELD_W-1:0]      src_b;
      logic [FIELD_W-1:0]      src_c;
      logic signed [IMM_W-1:0] imm;
      logic                    has_value;
      logic signed [31:0]      value;
   } directed_row_type;

   // registers 1, 2, 3 hold minimum, maximum and minus one for most rows
   localparam directed_row_type DIRECTED_ROWS [26] = '{
      '{OP_PRINT,   4'd0,  4'd0, 4'd0, 32'sd0,    1'b1, 32'sd0},
      '{OP_PRINT,   4'd15, 4'd0, 4'd0, 32'sd0,    1'b1, 32'sd0},
      '{OP_IMM,     4'd1,  4'd0, 4'd0, MIN_VALUE, 1'b0, 32'sd0},
      '{OP_IMM,     4'd2,  4'd0, 4'd0, MAX_VALUE, 1'b0, 32'sd0},
      '{OP_IMM,     4'd3,  4'd0, 4'd0, -32'sd1,   1'b0, 32'sd0},
      '{OP_PRINT,   4'd2,  4'd0, 4'd0, 32'sd0,    1'b1, MAX_VALUE},
      '{OP_DIV,     4'd4,  4'd1, 4'd3, 32'sd0,    1'b0, 32'sd0},
      '{OP_PRINT,   4'd4,  4'd0, 4'd0, 32'sd0,    1'b1, MIN_VALUE},
      '{OP_IMM,     4'd6,  4'd0, 4'd0, 32'sd12345, 1'b0, 32'sd0},
      '{OP_DIV,     4'd6,  4'd2, 4'd0, 32'sd0,    1'b0, 32'sd0},
      '{OP_PRINT,   4'd6,  4'd0, 4'd0, 32'sd0,    1'b1, 32'sd0},
      '{OP_ADD,     4'd7,  4'd2, 4'd2, 32'sd0,    1'b0, 32'sd0},
      '{OP_MUL,     4'd8,  4'd1, 4'd3, 32'sd0,    1'b0, 32'sd0},
      '{OP_SUB,     4'd9,  4'd1, 4'd2, 32'sd0,    1'b0, 32'sd0},
      '{OP_COPY,    4'd10, 4'd2, 4'd0, 32'sd0,    1'b0, 32'sd0},
      '{OP_LESS,    4'd11, 4'd1, 4'd2, 32'sd0,    1'b0, 32'sd0},
      '{OP_GREATER, 4'd12, 4'd1, 4'd2, 32'sd0,    1'b0, 32'sd0},
      '{OP_EQUAL,   4'd13, 4'd3, 4'd3, 32'sd0,    1'b0, 32'sd0},
      '{OP_NOT,     4'd14, 4'd0, 4'd0, 32'sd0,    1'b0, 32'sd0},
      '{OP_OR,      4'd15, 4'd0, 4'd3, 32'sd0,    1'b0, 32'sd0},
      '{OP_AND,     4'd5,  4'd3, 4'd0, 32'sd0,    1'b0, 32'sd0},
      '{OP_NOP,     4'd2,  4'd3, 4'd3, -32'sd1,   1'b0, 32'sd0},
      '{OP_RSVD_14, 4'd2,  4'd15, 4'd15, -32'sd1, 1'b0, 32'sd0},
      '{OP_RSVD_15, 4'd2,  4'd15, 4'd15, 32'sd0,  1'b0, 32'sd0},
      '{OP_PRINT,   4'd2,  4'd0, 4'd0, 32'sd0,    1'b1, MAX_VALUE},
      '{OP_PRINT,   4'd7,  4'd0, 4'd0, 32'sd0,    1'b0, 32'sd0}
   };

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [FIELD_W-1:0] req_type;
   logic [FIELD_W-1:0] req_dest_reg;
   logic [FIELD_W-1:0] req_src_b_reg;
   logic [FIELD_W-1:0] req_src_c_reg;
   logic signed [IMM_W-1:0] req_immediate;
   logic rsp_valid;
   logic rsp_ready;
   logic [FIELD_W-1:0] rsp_printed_reg;
   logic signed [PRINT_W-1:0] rsp_printed_value;

   logic signed [31:0] shadow_regs [16];
   printed_line_type expected_prints [$];
   printed_line_type oldest_print;
   int items_sent = 0;
   int errors = 0;
   int cycle_count = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   logic calm;

   assign calm = (items_sent >= CALM_FROM) && (items_sent < CALM_TO);

   register_alu_interpreter u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_dest_reg      (req_dest_reg),
      .req_src_b_reg     (req_src_b_reg),
      .req_src_c_reg     (req_src_c_reg),
      .req_immediate     (req_immediate),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_printed_reg   (rsp_printed_reg),
      .rsp_printed_value (rsp_printed_value)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // runs one instruction on the shadow register file; a print queues its line
   task automatic execute_instruction(input logic [FIELD_W-1:0] op, dest, src_b, src_c,
                                      input logic signed [31:0] imm,
                                      input logic has_value,
                                      input logic signed [31:0] value);
      logic signed [31:0] b;
      logic signed [31:0] c;
      logic signed [31:0] r;
      logic writes;
      printed_line_type line;
      b = shadow_regs[src_b];
      c = shadow_regs[src_c];
      r = '0;
      writes = 1'b1;
      case (op)
         OP_ADD:     r = b + c;
         OP_MUL:     r = b * c;
         OP_SUB:     r = b - c;
         OP_DIV: begin
            if (c == 0) begin
               r = '0;
            end else if (b == MIN_VALUE && c == -1) begin
               r = MIN_VALUE;
            end else begin
               r = b / c;
            end
         end
         OP_COPY:    r = b;
         OP_IMM:     r = imm;
         OP_LESS:    r = (b < c) ? 32'sd1 : 32'sd0;
         OP_GREATER: r = (b > c) ? 32'sd1 : 32'sd0;
         OP_EQUAL:   r = (b == c) ? 32'sd1 : 32'sd0;
         OP_NOT:     r = (b == 0) ? 32'sd1 : 32'sd0;
         OP_OR:      r = (b != 0 || c != 0) ? 32'sd1 : 32'sd0;
         OP_AND:     r = (b != 0 && c != 0) ? 32'sd1 : 32'sd0;
         OP_PRINT: begin
            writes = 1'b0;
            line.reg_index = dest;
            line.value = has_value ? value : shadow_regs[dest];
            expected_prints.push_back(line);
         end
         default:    writes = 1'b0;
      endcase
      if (writes) begin
         shadow_regs[dest] = r;
      end
   endtask

   task automatic send_item(input logic [FIELD_W-1:0] op, dest, src_b, src_c,
                            input logic signed [31:0] imm,
                            input logic has_value,
                            input logic signed [31:0] value);
      while (!calm && $urandom_range(0, 99) < 22) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= op;
      req_dest_reg  <= dest;
      req_src_b_reg <= src_b;
      req_src_c_reg <= src_c;
      req_immediate <= imm;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      execute_instruction(op, dest, src_b, src_c, imm, has_value, value);
      items_sent++;
   endtask

   // biased toward the values where wrap, sign and divide corners live
   function automatic logic signed [31:0] random_immediate();
      case ($urandom_range(0, 5))
         0:       return MIN_VALUE;
         1:       return MAX_VALUE;
         2:       return 32'($urandom_range(0, 16)) - 32'sd8;
         3:       return 32'($urandom_range(0, 2)) - 32'sd1;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int pick;
      logic [FIELD_W-1:0] op;
      for (int i = 0; i < 16; i++) begin
         shadow_regs[i] = '0;
      end
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_type      <= OP_NOP;
      req_dest_reg  <= '0;
      req_src_b_reg <= '0;
      req_src_c_reg <= '0;
      req_immediate <= '0;
      rsp_ready     <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         send_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].dest, DIRECTED_ROWS[i].src_b,
                   DIRECTED_ROWS[i].src_c, DIRECTED_ROWS[i].imm,
                   DIRECTED_ROWS[i].has_value, DIRECTED_ROWS[i].value);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            op = OP_IMM;
         end else if (pick < 33) begin
            op = OP_PRINT;
         end else if (pick < 93) begin
            op = FIELD_W'($urandom_range(OP_ADD, OP_AND));
         end else begin
            op = FIELD_W'($urandom_range(OP_NOP, OP_RSVD_15));
         end
         send_item(op, FIELD_W'($urandom_range(0, 15)), FIELD_W'($urandom_range(0, 15)),
                   FIELD_W'($urandom_range(0, 15)), random_immediate(), 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (expected_prints.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         if (expected_prints.size() == 0) begin
            $display("%0t: print transfer with none pending: reg %0d value %0d",
                     $time, rsp_printed_reg, rsp_printed_value);
            errors++;
         end else begin
            oldest_print = expected_prints.pop_front();
            if (rsp_printed_reg !== oldest_print.reg_index) begin
               $display("%0t: printed_reg expected %0d actual %0d",
                        $time, oldest_print.reg_index, rsp_printed_reg);
               errors++;
            end
            if (rsp_printed_value !== oldest_print.value) begin
               $display("%0t: printed_value expected %0d actual %0d",
                        $time, oldest_print.value, rsp_printed_value);
               errors++;
            end
         end
      end

      // one long hold-off so prints back up and the block stalls its input
      if (!hold_done && items_sent >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (calm) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= 22);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d prints pending", $time, expected_prints.size());
         $display("Test completed with failures");
         $finish;
      end
   end

endmodule
